// File: rtl/pfe_pkg.sv
// shared constants and types for the postfix expression evaluator
package pfe_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/pfe_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module pfe_divider
  import pfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    dvs_r, dvs_nxt;
  logic [DATA_W-1:0]    res_r, res_nxt;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 fits;
  logic [DATA_W-1:0]    quo_step;

  assign shifted  = {rem_r, quo_r[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvs_r};
  assign fits     = !diff[DATA_W];
  assign quo_step = {quo_r[DATA_W-2:0], fits};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    res_nxt  = res_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
      dvs_nxt  = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_nxt  = quo_step;
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (~quo_step + 1'b1) : quo_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> dvs_r != '0)
    else $error("divider running on zero divisor");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

// File: rtl/postfix_expression_evaluator_core.sv
// postfix expression evaluator top level with memory-backed value stack
// Takes one ASCII character per request on the input stream and evaluates a postfix
// expression on a 64-entry stack of 32-bit signed values; the top of stack lives in a
// register and the entries below it in a single-port synchronous memory. Only one
// character is worked on at a time: a push is stored on acceptance; + - * read the
// left operand from memory, then do the operation, and / then waits on the radix-2
// divider, which produces one quotient bit per cycle. The character marked
// by tlast emits one result: value in tdata, status in tuser (0 ok, 1 overflow,
// 2 division by zero, first error kept). A result waiting in the output register does
// not block the next characters; only a further final character waits for it.
module postfix_expression_evaluator_core
  import pfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        err_r, err_nxt;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  logic [7:0]        sym_r, sym_nxt;
  logic              last_r, last_nxt;
  logic              lhs_zero_r, lhs_zero_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa, mem_ra;

  logic              accept;
  logic              is_op;
  logic [DATA_W-1:0] lhs, rhs;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_op     = in_tdata inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  assign lhs       = lhs_zero_r ? '0 : rd_data_r;
  assign rhs       = tos_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    tos_nxt        = tos_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    lhs_zero_nxt   = lhs_zero_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = IDX_W'(cnt_r - 1'b1);
    mem_ra         = IDX_W'(cnt_r - CNT_W'(2));
    div_req.start    = 1'b0;
    div_req.dividend = lhs;
    div_req.divisor  = rhs;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sym_nxt  = in_tdata;
          last_nxt = in_tlast;
          if (is_op && cnt_r != '0) begin
            lhs_zero_nxt = (cnt_r == CNT_W'(1));
            mem_re       = (cnt_r != CNT_W'(1));
            state_nxt    = S_EXEC;
          end else begin
            if (cnt_r == CNT_W'(STACK_DEPTH)) begin
              if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
            end else begin
              mem_we  = (cnt_r != '0);
              tos_nxt = {{(DATA_W-8){1'b0}}, in_tdata} - {{(DATA_W-8){1'b0}}, CH_ZERO};
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = S_FIN;
          end
        end
      end
      S_EXEC: begin
        if (!lhs_zero_r) cnt_nxt = cnt_r - 1'b1;
        state_nxt = S_FIN;
        case (sym_r)
          CH_PLUS:  tos_nxt = lhs + rhs;
          CH_MINUS: tos_nxt = lhs - rhs;
          CH_STAR:  tos_nxt = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              tos_nxt = '0;
              if (err_r == ST_OK) err_nxt = ST_DIVZERO;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_nxt   = div_rsp.quotient;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (cnt_r != '0) ? tos_r : '0;
          out_status_nxt = err_r;
          cnt_nxt        = '0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= tos_r;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tos_r        <= tos_nxt;
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    lhs_zero_r   <= lhs_zero_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  pfe_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK && state_r != S_FIN) |=> $stable(err_r))
    else $error("error status changed mid expression");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider result outside divide state");

endmodule

// File: dv/postfix_expression_evaluator_core_test.sv
// self-checking stream testbench for the postfix expression evaluator core
`timescale 1ns / 100ps

module postfix_expression_evaluator_core_test;
  import pfe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [1:0]        status;
  } expr_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] symbol
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] value
  logic [1:0]  out_tuser;          // [1:0] status

  postfix_expression_evaluator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predicted evaluator state
  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int unsigned       model_depth = 0;
  logic [1:0]        model_status = ST_OK;
  expr_result_t      expected_results [$];
  expr_result_t      oldest_result;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned sent_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  logic [7:0] operator_codes [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_operator(input logic [7:0] sym);
    return sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH;
  endfunction

  function automatic void note_status(input logic [1:0] code);
    if (model_status == ST_OK) model_status = code;
  endfunction

  function automatic void model_push(input logic [DATA_W-1:0] v);
    if (model_depth >= STACK_DEPTH) begin
      note_status(ST_OVERFLOW);
    end else begin
      model_stack[model_depth] = v;
      model_depth++;
    end
  endfunction

  function automatic logic [DATA_W-1:0] model_pop();
    if (model_depth == 0) return '0;
    model_depth--;
    return model_stack[model_depth];
  endfunction

  function automatic logic [DATA_W-1:0] combine(input logic [7:0] op,
                                                input logic [DATA_W-1:0] lhs,
                                                input logic [DATA_W-1:0] rhs);
    longint l;
    longint r;
    longint q;
    case (op)
      CH_PLUS:  return lhs + rhs;
      CH_MINUS: return lhs - rhs;
      CH_STAR:  return lhs * rhs;
      default: begin
        if (rhs == '0) begin
          note_status(ST_DIVZERO);
          return '0;
        end
        l = $signed(lhs);
        r = $signed(rhs);
        q = l / r;
        return q[DATA_W-1:0];
      end
    endcase
  endfunction

  // advance the predicted state by one accepted request
  function automatic void eval_symbol(input logic [7:0] sym, input logic lst);
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] lhs;
    expr_result_t      res;
    if (is_operator(sym) && model_depth > 0) begin
      rhs = model_pop();
      lhs = model_pop();
      model_push(combine(sym, lhs, rhs));
    end else begin
      model_push({24'd0, sym} - {24'd0, CH_ZERO});
    end
    if (lst) begin
      res.value  = (model_depth > 0) ? model_stack[model_depth - 1] : '0;
      res.status = model_status;
      expected_results.push_back(res);
      model_depth  = 0;
      model_status = ST_OK;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic send_symbol(input logic [7:0] sym, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    eval_symbol(sym, lst);
    sent_items++;
  endtask

  task automatic send_digit(input int d, input logic lst);
    send_symbol(CH_ZERO + 8'(d), lst);
  endtask

  task automatic send_sequence(input logic [7:0] syms [$]);
    foreach (syms[i]) send_symbol(syms[i], i == syms.size() - 1);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_operand();
    logic [7:0] sym;
    if ($urandom_range(3) != 0) return CH_ZERO + 8'($urandom_range(9));
    do sym = 8'($urandom_range(255)); while (is_operator(sym));
    return sym;
  endfunction

  // response side: random stalls and result compare
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d",
                                  $signed(out_tdata), out_tuser));
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_tdata !== oldest_result.value)
          report_mismatch($sformatf("value %0d, predicted %0d", $signed(out_tdata),
                                    $signed(oldest_result.value)));
        if (out_tuser !== oldest_result.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_tuser,
                                    oldest_result.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("postfix_expression_evaluator_core test failed");
      $finish;
    end
  end

  task automatic test_arithmetic();
    // (3 - 7) * 8
    send_digit(3, 1'b0);
    send_digit(7, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_digit(8, 1'b0);
    send_symbol(CH_STAR, 1'b1);
    // negative quotient truncates toward zero
    send_digit(0, 1'b0);
    send_digit(5, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_digit(2, 1'b0);
    send_symbol(CH_SLASH, 1'b1);
  endtask

  task automatic test_operand_shortage();
    // operator on empty stack pushes itself
    send_symbol(CH_PLUS, 1'b1);
    // single operand: left side is zero
    send_digit(9, 1'b0);
    send_symbol(CH_MINUS, 1'b1);
  endtask

  task automatic test_character_extremes();
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(CH_PLUS, 1'b1);
  endtask

  task automatic test_divide_cases();
    send_digit(5, 1'b0);
    send_digit(0, 1'b0);
    send_symbol(CH_SLASH, 1'b1);
    // build the most negative value, then divide it by minus one
    send_symbol(8'hB0, 1'b0);
    repeat (3) begin
      send_symbol(8'hB0, 1'b0);
      send_symbol(CH_STAR, 1'b0);
    end
    send_digit(8, 1'b0);
    send_symbol(CH_STAR, 1'b0);
    send_digit(0, 1'b0);
    send_digit(1, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_SLASH, 1'b1);
  endtask

  task automatic send_wellformed_expression();
    logic [7:0] syms [$];
    int operands;
    int depth;
    int pushed;
    operands = $urandom_range(1, 8);
    depth = 0;
    pushed = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(1) == 1)) begin
        syms.push_back(random_operand());
        pushed++;
        depth++;
      end else begin
        syms.push_back(operator_codes[$urandom_range(3)]);
        depth--;
      end
    end
    send_sequence(syms);
  endtask

  task automatic send_deep_expression();
    logic [7:0] syms [$];
    int pushes;
    int ops;
    pushes = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
    ops = $urandom_range(0, 6);
    repeat (pushes) syms.push_back(random_operand());
    repeat (ops) syms.push_back(operator_codes[$urandom_range(3)]);
    send_sequence(syms);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_symbol(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic test_random_expressions(input int send_pct, input int recv_pct,
                                         input int item_goal);
    int unsigned first;
    int pick;
    bit paused;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    first = sent_items;
    paused = 1'b0;
    while (sent_items - first < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 2) send_deep_expression();
      else if (pick < 17) send_noise();
      else send_wellformed_expression();
      if (!paused && sent_items - first >= item_goal / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 6;
    recv_stall_pct = 80;
    test_arithmetic();
    test_operand_shortage();
    test_character_extremes();
    test_divide_cases();
    wait_results_drained();
    test_random_expressions(6, 80, 384);
    test_random_expressions(80, 6, 384);
    test_random_expressions(0, 0, 384);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("postfix_expression_evaluator_core test passed");
    end else begin
      $display("postfix_expression_evaluator_core test failed");
    end
    $finish;
  end

endmodule
